// ===== rtl/cfii_pkg.sv =====
`default_nettype none

package cfii_pkg;

  // Register file size and the index width it needs
  localparam int NUM_REGS = 16;
  localparam int REG_W    = $clog2(NUM_REGS);

  localparam logic [31:0] UNSET_RULE = 32'hffff_ffff;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_ALIGN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_ALIGN = 1'b1;

  // Reset values of the alignment factors
  localparam logic signed [6:0] CODE_ALIGN_RESET = 7'sd1;
  localparam logic signed [6:0] DATA_ALIGN_RESET = -7'sd4;

  // Instruction kind, top two bits of an instruction byte
  localparam logic [1:0] KIND_EXTENDED = 2'd0;
  localparam logic [1:0] KIND_ADVANCE  = 2'd1;
  localparam logic [1:0] KIND_OFFSET   = 2'd2;
  localparam logic [1:0] KIND_RESTORE  = 2'd3;

  // Low six bits of the extended kind
  localparam logic [5:0] OP_NOP            = 6'h00;
  localparam logic [5:0] OP_ADVANCE_LOC1   = 6'h02;
  localparam logic [5:0] OP_REMEMBER_STATE = 6'h0a;
  localparam logic [5:0] OP_RESTORE_STATE  = 6'h0b;
  localparam logic [5:0] OP_DEF_CFA_OFFSET = 6'h0e;

  typedef enum logic [1:0] {
    ACT_START,
    ACT_BYTE,
    ACT_READ,
    ACT_NONE
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE,
    ST_WAIT_OPERAND,
    ST_PAST_TARGET,
    ST_UNKNOWN
  } status_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  data_byte;
    logic [31:0] start_location;
    logic [31:0] target_address;
    logic [3:0]  reg_index;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] location;
    logic [31:0] frame_offset;
    logic [31:0] reg_offset;
    logic        past_target;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/cfii_core.sv =====
`default_nettype none

module cfii_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire cfii_pkg::item_t    item,
  input  wire logic signed [6:0]  code_align,
  input  wire logic signed [6:0]  data_align,
  output cfii_pkg::result_t       result
);
  import cfii_pkg::*;

  // Unwind row state
  logic [7:0]  pending_opcode, pending_opcode_next;
  logic        operand_expected, operand_expected_next;
  logic [31:0] row_location, row_location_next;
  logic [31:0] row_frame_offset, row_frame_offset_next;
  logic [31:0] remembered_frame_offset, remembered_frame_offset_next;
  logic [31:0] target_location, target_location_next;
  logic [31:0] register_rules [NUM_REGS];
  logic [31:0] register_rules_next [NUM_REGS];
  logic [31:0] remembered_rules [NUM_REGS];
  logic [31:0] remembered_rules_next [NUM_REGS];

  logic [1:0]        byte_kind, pend_kind;
  logic [5:0]        byte_low, pend_low;
  logic              byte_reg_ok, pend_reg_ok;
  logic signed [13:0] advance_prod;
  logic signed [14:0] offset_prod;
  logic              row_past;
  status_t           status;

  assign byte_kind   = item.data_byte[7:6];
  assign byte_low    = item.data_byte[5:0];
  assign pend_kind   = pending_opcode[7:6];
  assign pend_low    = pending_opcode[5:0];
  assign byte_reg_ok = (32'(byte_low) < NUM_REGS);
  assign pend_reg_ok = (32'(pend_low) < NUM_REGS);
  assign row_past    = (row_location > target_location);

  // Scale the advance delta and the offset operand
  assign advance_prod = code_align * $signed({1'b0, byte_low});
  assign offset_prod  = $signed({1'b0, item.data_byte[6:0]}) * data_align;

  // Work out the state after this item
  always_comb begin
    pending_opcode_next          = pending_opcode;
    operand_expected_next        = operand_expected;
    row_location_next            = row_location;
    row_frame_offset_next        = row_frame_offset;
    remembered_frame_offset_next = remembered_frame_offset;
    target_location_next         = target_location;
    register_rules_next          = register_rules;
    remembered_rules_next        = remembered_rules;
    status                       = ST_DONE;

    case (item.action)
      ACT_START: begin
        row_location_next     = item.start_location;
        target_location_next  = item.target_address;
        row_frame_offset_next = '0;
        for (int i = 0; i < NUM_REGS; i++) begin
          register_rules_next[i] = UNSET_RULE;
        end
        operand_expected_next = 1'b0;
        pending_opcode_next   = '0;
      end
      ACT_BYTE: begin
        if (operand_expected) begin
          // Consume the operand of the pending instruction
          operand_expected_next = 1'b0;
          if (pend_kind == KIND_OFFSET) begin
            if (pend_reg_ok) begin
              register_rules_next[pend_low[REG_W-1:0]] =
                {{17{offset_prod[14]}}, offset_prod};
            end
          end else if (pend_low == OP_ADVANCE_LOC1) begin
            row_location_next = row_location + {24'b0, item.data_byte};
          end else begin
            row_frame_offset_next = {25'b0, item.data_byte[6:0]};
          end
        end else if (row_past) begin
          status = ST_PAST_TARGET;
        end else begin
          case (byte_kind)
            KIND_ADVANCE: begin
              row_location_next = row_location + {{18{advance_prod[13]}}, advance_prod};
            end
            KIND_OFFSET: begin
              pending_opcode_next   = item.data_byte;
              operand_expected_next = 1'b1;
              status                = ST_WAIT_OPERAND;
            end
            KIND_RESTORE: begin
              if (byte_reg_ok) begin
                register_rules_next[byte_low[REG_W-1:0]] =
                  remembered_rules[byte_low[REG_W-1:0]];
              end
            end
            default: begin
              case (byte_low)
                OP_NOP: ;
                OP_ADVANCE_LOC1, OP_DEF_CFA_OFFSET: begin
                  pending_opcode_next   = item.data_byte;
                  operand_expected_next = 1'b1;
                  status                = ST_WAIT_OPERAND;
                end
                OP_REMEMBER_STATE: begin
                  remembered_rules_next        = register_rules;
                  remembered_frame_offset_next = row_frame_offset;
                end
                OP_RESTORE_STATE: begin
                  register_rules_next   = remembered_rules;
                  row_frame_offset_next = remembered_frame_offset;
                end
                default: status = ST_UNKNOWN;
              endcase
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  // Report the row after this item
  always_comb begin
    result.status       = status;
    result.location     = row_location_next;
    result.frame_offset = row_frame_offset_next;
    result.reg_offset   = (32'(item.reg_index) < NUM_REGS) ?
                          register_rules_next[REG_W'(item.reg_index)] : UNSET_RULE;
    result.past_target  = (row_location_next > target_location_next);
  end

  // Hold state, advance it on each processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_opcode          <= '0;
      operand_expected        <= 1'b0;
      row_location            <= '0;
      row_frame_offset        <= '0;
      remembered_frame_offset <= '0;
      target_location         <= '0;
      for (int i = 0; i < NUM_REGS; i++) begin
        register_rules[i]   <= UNSET_RULE;
        remembered_rules[i] <= '0;
      end
    end else if (en) begin
      pending_opcode          <= pending_opcode_next;
      operand_expected        <= operand_expected_next;
      row_location            <= row_location_next;
      row_frame_offset        <= row_frame_offset_next;
      remembered_frame_offset <= remembered_frame_offset_next;
      target_location         <= target_location_next;
      register_rules          <= register_rules_next;
      remembered_rules        <= remembered_rules_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/call_frame_instruction_interpreter.sv =====
`default_nettype none

// Channel  Handshake             Payload
// -------  --------------------  ---------------------------------------------
// in       in_valid / in_stall   action, data_byte, start_location,
//                                target_address, reg_index
// out      out_valid / out_stall status, location, frame_offset, reg_offset,
//                                past_target
// cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; an accepted item passes the input register
// and then the result register (decode and row update run from the one into the other).
// The row state loop holds decode, a small multiply, a 32-bit add and compare.
// Synchronous reset clears the row, sets every rule unset and the factors to 1, -4.
// A stalled result holds; the input register still takes one more item behind it,
// and cfg_ready is always high.

module call_frame_instruction_interpreter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  action,
  input  wire logic [7:0]  data_byte,
  input  wire logic [31:0] start_location,
  input  wire logic [31:0] target_address,
  input  wire logic [3:0]  reg_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [31:0]      location,
  output logic [31:0]      frame_offset,
  output logic [31:0]      reg_offset,
  output logic             past_target,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [cfii_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [6:0]  cfg_data
);
  import cfii_pkg::*;

  logic signed [6:0] code_align;
  logic signed [6:0] data_align;
  logic              s1_valid;
  item_t             s1_item;
  logic              advance;
  logic              in_load;
  result_t           core_result;
  result_t           out_result;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      code_align <= CODE_ALIGN_RESET;
      data_align <= DATA_ALIGN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CODE_ALIGN: code_align <= cfg_data;
        CFG_DATA_ALIGN: data_align <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance when the result register is free or being drained
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign in_load  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_load) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      s1_item.action         <= action_t'(action);
      s1_item.data_byte      <= data_byte;
      s1_item.start_location <= start_location;
      s1_item.target_address <= target_address;
      s1_item.reg_index      <= reg_index;
    end
  end

  cfii_core u_core (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .item       (s1_item),
    .code_align (code_align),
    .data_align (data_align),
    .result     (core_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign status       = out_result.status;
  assign location     = out_result.location;
  assign frame_offset = out_result.frame_offset;
  assign reg_offset   = out_result.reg_offset;
  assign past_target  = out_result.past_target;

`ifndef NO_ASSERTIONS
  // Back-pressure on the input only while an item is held
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty input register");

  // A held item that cannot advance stays held
  a_item_kept: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> s1_valid)
    else $error("held item dropped");

  // A byte ignored past the target reports the row as past the target
  a_past_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_PAST_TARGET) |-> past_target)
    else $error("past-target status without past_target flag");
`endif

endmodule

`default_nettype wire

// ===== test/call_frame_instruction_interpreter_tb.sv =====
`timescale 1ns / 1ps

// Unwind row predictor plus the queue of rows it still expects from the block
class cfa_row_scoreboard;
  logic [6:0]  code_align;
  logic [6:0]  data_align;
  logic [7:0]  held_opcode;
  bit          operand_due;
  logic [31:0] row_loc;
  logic [31:0] row_cfa;
  logic [31:0] target_loc;
  logic [31:0] saved_cfa;
  logic [31:0] rules [cfii_pkg::NUM_REGS];
  logic [31:0] saved_rules [cfii_pkg::NUM_REGS];
  cfii_pkg::result_t row_q [$];
  int errors;

  function new();
    code_align  = cfii_pkg::CODE_ALIGN_RESET;
    data_align  = cfii_pkg::DATA_ALIGN_RESET;
    held_opcode = '0;
    operand_due = 0;
    row_loc     = '0;
    row_cfa     = '0;
    target_loc  = '0;
    saved_cfa   = '0;
    foreach (rules[i]) begin
      rules[i]       = cfii_pkg::UNSET_RULE;
      saved_rules[i] = '0;
    end
    errors = 0;
  endfunction

  function logic [31:0] widen7(logic [6:0] v);
    return {{25{v[6]}}, v};
  endfunction

  function void write_reg(logic [cfii_pkg::CFG_IDX_W-1:0] idx, logic [6:0] value);
    if (idx == cfii_pkg::CFG_CODE_ALIGN) code_align = value;
    else if (idx == cfii_pkg::CFG_DATA_ALIGN) data_align = value;
  endfunction

  // Finish an instruction that was waiting for its operand byte
  function void apply_operand(logic [7:0] arg);
    logic [1:0] kind;
    logic [5:0] low;
    kind = held_opcode[7:6];
    low  = held_opcode[5:0];
    if (kind == cfii_pkg::KIND_OFFSET) begin
      if (low < cfii_pkg::NUM_REGS) rules[low] = {25'b0, arg[6:0]} * widen7(data_align);
    end else if (low == cfii_pkg::OP_ADVANCE_LOC1) begin
      row_loc = row_loc + {24'b0, arg};
    end else begin
      row_cfa = {25'b0, arg[6:0]};
    end
  endfunction

  // Decode a fresh instruction byte and return its status
  function cfii_pkg::status_t decode(logic [7:0] b);
    logic [5:0] low;
    low = b[5:0];
    case (b[7:6])
      cfii_pkg::KIND_ADVANCE: row_loc = row_loc + widen7(code_align) * {26'b0, low};
      cfii_pkg::KIND_OFFSET: begin
        held_opcode = b;
        operand_due = 1;
        return cfii_pkg::ST_WAIT_OPERAND;
      end
      cfii_pkg::KIND_RESTORE: begin
        if (low < cfii_pkg::NUM_REGS) rules[low] = saved_rules[low];
      end
      default: begin
        case (low)
          cfii_pkg::OP_NOP: ;
          cfii_pkg::OP_ADVANCE_LOC1, cfii_pkg::OP_DEF_CFA_OFFSET: begin
            held_opcode = b;
            operand_due = 1;
            return cfii_pkg::ST_WAIT_OPERAND;
          end
          cfii_pkg::OP_REMEMBER_STATE: begin
            foreach (rules[i]) saved_rules[i] = rules[i];
            saved_cfa = row_cfa;
          end
          cfii_pkg::OP_RESTORE_STATE: begin
            foreach (rules[i]) rules[i] = saved_rules[i];
            row_cfa = saved_cfa;
          end
          default: return cfii_pkg::ST_UNKNOWN;
        endcase
      end
    endcase
    return cfii_pkg::ST_DONE;
  endfunction

  // Advance the row by one accepted item and queue the row it should report
  function void note_item(cfii_pkg::item_t it);
    cfii_pkg::result_t row;
    cfii_pkg::status_t st;
    st = cfii_pkg::ST_DONE;
    case (it.action)
      cfii_pkg::ACT_START: begin
        row_loc    = it.start_location;
        target_loc = it.target_address;
        row_cfa    = '0;
        foreach (rules[i]) rules[i] = cfii_pkg::UNSET_RULE;
        operand_due = 0;
        held_opcode = '0;
      end
      cfii_pkg::ACT_BYTE: begin
        if (operand_due) begin
          operand_due = 0;
          apply_operand(it.data_byte);
        end else if (row_loc > target_loc) begin
          st = cfii_pkg::ST_PAST_TARGET;
        end else begin
          st = decode(it.data_byte);
        end
      end
      default: ;
    endcase
    row.status       = st;
    row.location     = row_loc;
    row.frame_offset = row_cfa;
    row.reg_offset   = (it.reg_index < cfii_pkg::NUM_REGS) ? rules[it.reg_index]
                                                            : cfii_pkg::UNSET_RULE;
    row.past_target  = (row_loc > target_loc);
    row_q.push_back(row);
  endfunction

  function void flag(string msg);
    errors++;
    if (errors <= 10) $display("%t mismatch: %s", $realtime, msg);
  endfunction

  // Compare one delivered row with the oldest queued one
  function void check_result(cfii_pkg::result_t got);
    cfii_pkg::result_t want;
    if (row_q.size() == 0) begin
      flag($sformatf("row with nothing queued: status %0d loc %h cfa %h rule %h past %b",
                     got.status, got.location, got.frame_offset, got.reg_offset,
                     got.past_target));
      return;
    end
    want = row_q.pop_front();
    if (got.status !== want.status || got.location !== want.location ||
        got.frame_offset !== want.frame_offset || got.reg_offset !== want.reg_offset ||
        got.past_target !== want.past_target)
      flag($sformatf({"expected status %0d loc %h cfa %h rule %h past %b, ",
                      "got status %0d loc %h cfa %h rule %h past %b"},
                     want.status, want.location, want.frame_offset, want.reg_offset,
                     want.past_target, got.status, got.location, got.frame_offset,
                     got.reg_offset, got.past_target));
  endfunction
endclass

module call_frame_instruction_interpreter_tb;
  import cfii_pkg::*;

  logic clk = 0;
  logic rst = 1;

  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  action = '0;
  logic [7:0]  data_byte = '0;
  logic [31:0] start_location = '0;
  logic [31:0] target_address = '0;
  logic [3:0]  reg_index = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  status;
  logic [31:0] location;
  logic [31:0] frame_offset;
  logic [31:0] reg_offset;
  logic        past_target;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [6:0]  cfg_data = '0;

  cfa_row_scoreboard sb = new();

  int burst_left = 4;
  int stall_left = 0;
  int stall_mode = 0;
  int items_sent = 0;

  call_frame_instruction_interpreter dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .data_byte(data_byte), .start_location(start_location),
    .target_address(target_address), .reg_index(reg_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .location(location), .frame_offset(frame_offset),
    .reg_offset(reg_offset), .past_target(past_target),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("call_frame_instruction_interpreter regression: fail");
    $finish;
  end

  // Watch all three channels and feed the scoreboard
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall)
        sb.note_item('{action: action_t'(action), data_byte: data_byte,
                       start_location: start_location, target_address: target_address,
                       reg_index: reg_index});
      if (out_valid && !out_stall)
        sb.check_result('{status: status_t'(status), location: location,
                          frame_offset: frame_offset, reg_offset: reg_offset,
                          past_target: past_target});
    end
  end

  // Receiver backpressure: switch between free flow, light, heavy and periodic stalls
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(10, 80);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ((stall_left % 12) < 5);
    endcase
  end

  function automatic item_t any_item(action_t a);
    item_t it;
    it.action         = a;
    it.data_byte      = 8'($urandom);
    it.start_location = $urandom;
    it.target_address = $urandom;
    it.reg_index      = 4'($urandom);
    return it;
  endfunction

  // Drive one item, hold it until taken, then maybe open a gap
  task automatic push_item(item_t it);
    in_valid       <= 1;
    action         <= it.action;
    data_byte      <= it.data_byte;
    start_location <= it.start_location;
    target_address <= it.target_address;
    reg_index      <= it.reg_index;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 20);
    end
  endtask

  task automatic send_byte(logic [7:0] b);
    item_t it;
    it = any_item(ACT_BYTE);
    it.data_byte = b;
    push_item(it);
  endtask

  task automatic send_start(logic [31:0] loc, logic [31:0] tgt);
    item_t it;
    it = any_item(ACT_START);
    it.start_location = loc;
    it.target_address = tgt;
    push_item(it);
  endtask

  // Hold the sender until every queued row has come back
  task automatic drain();
    in_valid <= 0;
    while (sb.row_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both alignment factors back to back while idle
  task automatic set_align(logic [6:0] ca, logic [6:0] da);
    cfg_valid <= 1;
    cfg_index <= CFG_CODE_ALIGN;
    cfg_data  <= ca;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_DATA_ALIGN;
    cfg_data  <= da;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  function automatic logic [5:0] pick_reg();
    return ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 15));
  endfunction

  // Mostly well-formed instruction streams with random content, some noise
  task automatic run_random(int count);
    int stop;
    int r;
    logic [31:0] loc;
    logic [5:0] low;
    stop = items_sent + count;
    while (items_sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        loc = ($urandom_range(0, 4) == 0) ? 32'hffff_ffff - $urandom_range(0, 300) : $urandom;
        send_start(loc, ($urandom_range(0, 4) == 0) ? $urandom
                                                    : loc + $urandom_range(0, 4000));
      end else if (r < 25) begin
        send_byte({KIND_ADVANCE, 6'($urandom)});
      end else if (r < 40) begin
        send_byte({KIND_OFFSET, pick_reg()});
        send_byte(8'($urandom));
      end else if (r < 48) begin
        send_byte({KIND_RESTORE, pick_reg()});
      end else if (r < 55) begin
        send_byte({KIND_EXTENDED, OP_DEF_CFA_OFFSET});
        send_byte(8'($urandom));
      end else if (r < 60) begin
        send_byte({KIND_EXTENDED, OP_ADVANCE_LOC1});
        send_byte(8'($urandom));
      end else if (r < 65) begin
        send_byte({KIND_EXTENDED, OP_REMEMBER_STATE});
      end else if (r < 70) begin
        send_byte({KIND_EXTENDED, OP_RESTORE_STATE});
      end else if (r < 73) begin
        send_byte({KIND_EXTENDED, OP_NOP});
      end else if (r < 78) begin
        low = 6'($urandom);
        while (low == OP_NOP || low == OP_ADVANCE_LOC1 || low == OP_REMEMBER_STATE ||
               low == OP_RESTORE_STATE || low == OP_DEF_CFA_OFFSET)
          low = 6'($urandom);
        send_byte({KIND_EXTENDED, low});
      end else if (r < 88) begin
        push_item(any_item(ACT_READ));
      end else if (r < 90) begin
        push_item(any_item(ACT_NONE));
      end else begin
        send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: every instruction and corner under the reset factors
    push_item(any_item(ACT_READ));
    send_start(32'hffff_fff0, 32'hffff_ffff);
    send_byte({KIND_EXTENDED, OP_NOP});
    send_byte({KIND_ADVANCE, 6'h3f});
    send_byte({KIND_OFFSET, 6'h0f});
    send_byte(8'hff);
    send_byte({KIND_OFFSET, 6'h10});
    send_byte(8'h55);
    send_byte({KIND_EXTENDED, OP_DEF_CFA_OFFSET});
    push_item(any_item(ACT_READ));
    send_byte(8'hff);
    send_byte({KIND_EXTENDED, OP_REMEMBER_STATE});
    send_byte({KIND_RESTORE, 6'h01});
    send_byte({KIND_RESTORE, 6'h10});
    send_byte({KIND_EXTENDED, OP_RESTORE_STATE});
    send_byte({KIND_EXTENDED, 6'h01});
    send_byte({KIND_EXTENDED, 6'h3f});
    send_byte({KIND_OFFSET, 6'h03});
    send_start(32'h0, 32'h0);
    send_byte({KIND_EXTENDED, OP_ADVANCE_LOC1});
    send_byte(8'hff);
    send_byte({KIND_OFFSET, 6'h00});
    push_item(any_item(ACT_NONE));
    send_start(32'hffff_ffff, 32'hffff_ffff);
    send_byte({KIND_ADVANCE, 6'h3f});

    // Random phases across factor settings, extremes included
    run_random(275);
    drain();
    set_align(7'h3f, 7'h40);
    run_random(275);
    drain();
    set_align(7'h40, 7'h3f);
    run_random(275);
    drain();
    set_align(7'h00, 7'h00);
    run_random(275);
    drain();
    set_align(7'($urandom), 7'($urandom));
    run_random(275);
    drain();
    set_align(CODE_ALIGN_RESET, DATA_ALIGN_RESET);
    run_random(275);
    drain();

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.row_q.size() == 0) begin
      $display("call_frame_instruction_interpreter regression: pass");
    end else begin
      $display("call_frame_instruction_interpreter regression: fail");
    end
    $finish;
  end
endmodule
